// ===== hw/rtl/fsqrt_pkg.sv =====
// ----------------------------------------------------------------------------
// fsqrt_pkg
// Shared types and constants for the single-precision square root block.
// ----------------------------------------------------------------------------
package fsqrt_pkg;
    localparam int WORD_W = 32;
    localparam int RAD_W = 50;
    localparam int ROOT_W = 25;
    localparam int STEPS = 25;
    localparam int CNT_W = 5;
    localparam logic [31:0] EXP_MASK = 32'h7F80_0000;
    localparam logic [31:0] QUIET_NAN = 32'h7FC0_0000;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic special;
        logic last;
    } t_status;
endpackage

// ===== hw/rtl/fsqrt_if.sv =====
// ----------------------------------------------------------------------------
// fsqrt_if
// Valid/ready channel carrying one 32-bit word.
// ----------------------------------------------------------------------------
interface fsqrt_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/fsqrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsqrt_ctrl
// Sequencer: load, iterate the root recurrence, round, hold the result; special inputs skip straight to the hold.
// ----------------------------------------------------------------------------
module fsqrt_ctrl
    import fsqrt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_FIN  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_status.special) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_status.last) n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule

// ===== hw/rtl/fsqrt_dp.sv =====
// ----------------------------------------------------------------------------
// fsqrt_dp
// Datapath: unpack, one root bit per step, round and pack.
// ----------------------------------------------------------------------------
module fsqrt_dp
    import fsqrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_operand,
    output t_status     o_status,
    output logic [31:0] o_root
);
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_res;
    logic [RAD_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic [8:0]        r_exp;
    logic              r_special;
    logic [31:0]       r_out;

    // unpack
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [4:0]  lz;
    logic [23:0] m0;
    logic [9:0]  e0; // ex-1, or -1-lz for subnormal, signed
    logic [25:0] m1;
    logic [9:0]  e1;
    always_comb begin
        ex = i_operand[30:23];
        fr = i_operand[22:0];
        lz = '0;
        for (int i = 0; i < 23; i++) if (fr[i]) lz = 5'(22 - i);
        if (ex == 8'd0) begin
            m0 = {1'b0, fr} << (lz + 5'd1);
            e0 = 10'd0 - {5'd0, lz} - 10'd1;
        end else begin
            m0 = {1'b1, fr};
            e0 = {2'b00, ex} - 10'd1;
        end
        // value = m0 * 2^(e0-149); adjust so exponent is even
        if (!e0[0]) begin
            m1 = {1'b0, m0, 1'b0};
            e1 = e0;
        end else begin
            m1 = {m0, 2'b00};
            e1 = e0 - 10'd1;
        end
    end

    // recurrence on a 2-bit-per-step window
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W+1:0] part;
    always_comb begin
        part = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
        trial = {r_res, 2'b01};
    end
    logic ge;
    assign ge = part >= trial;

    logic [24:0] rnd_q;
    always_comb begin
        rnd_q = {1'b0, r_res[24:1]};
        if (r_res[0] && (r_rem != '0 || r_res[1])) rnd_q = rnd_q + 25'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_special <= 1'b0;
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
            r_special <= 1'b1;
            if (ex == 8'hFF && fr != '0) r_out <= QUIET_NAN;
            else if (i_operand[30:0] == '0 || i_operand[31]) r_out <= '0;
            else if (ex == 8'hFF) r_out <= EXP_MASK;
            else r_special <= 1'b0;
            r_rad <= {m1, 24'd0};
            r_res <= '0;
            r_rem <= '0;
            // value = m1 * 2^(e1-150), so result biased exponent = e1/2 + 64
            r_exp <= 9'($signed(e1) >>> 1) + 9'd64;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + 5'd1;
            r_rad <= r_rad << 2;
            if (ge) begin
                r_rem <= RAD_W'(part - trial);
                r_res <= {r_res[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem <= RAD_W'(part);
                r_res <= {r_res[ROOT_W-2:0], 1'b0};
            end
        end else if (i_cmd.finish) begin
            r_special <= 1'b0;
            r_out <= {1'b0, r_exp[7:0] + 8'(rnd_q[24]),
                      23'(rnd_q[24] ? rnd_q[23:1] : rnd_q[22:0])};
        end
    end

    assign o_status.special = r_special;
    assign o_status.last = (r_cnt == CNT_W'(STEPS - 1));
    assign o_root = r_out;
endmodule

// ===== hw/rtl/float_square_root.sv =====
// ----------------------------------------------------------------------------
// float_square_root
// IEEE-754 single-precision square root, round to nearest even.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (sink):   operand_bits, one request at a time.
//   out_ch (source): root_bits, held until taken.
// A request runs the radix-2 root recurrence (one root bit per step, set by
// the shared subtract/compare), then a round step. Special inputs (NaN,
// zero, negative, infinity) skip the recurrence and go straight to the
// result. The next request is accepted the cycle after the result is taken;
// a new request is not taken while one is in flight.
// Synchronous active-low reset returns the sequencer to idle; no request is
// in flight after reset. A stalled receiver holds the result stable and
// blocks new requests.
// Zero and negative inputs give +0, +inf gives +inf, NaN gives 0x7FC00000.
// ----------------------------------------------------------------------------
module float_square_root
    import fsqrt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    fsqrt_if.sink   in_ch,
    fsqrt_if.source out_ch
);
    t_cmd    cmd;
    t_status status;

    fsqrt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_status(status), .o_cmd(cmd)
    );

    fsqrt_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_operand(in_ch.data), .o_status(status), .o_root(out_ch.data)
    );
endmodule

// ===== hw/rtl/fsqrt_checker.sv =====
// ----------------------------------------------------------------------------
// fsqrt_checker
// Port-level checks for the square root block.
// ----------------------------------------------------------------------------
module fsqrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_data
);
    // never accepts while holding a result
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid)) else $error("ready while result pending");
    // no result and no second accept right after an accepted request
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_out_valid && !i_in_ready)
        else $error("early result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_out_data))
        else $error("result dropped");
    // result is never negative
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_out_data[31]) else $error("negative root");
endmodule

bind float_square_root fsqrt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
    .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
    .i_out_data(out_ch.data)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives float_square_root with directed special values and random operands
// under several sender/receiver idling mixes; every root is compared with a
// bit-exact round-to-nearest-even square root computed here.
// ----------------------------------------------------------------------------
module testbench;
    import fsqrt_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fsqrt_if in_ch ();
    fsqrt_if out_ch ();

    float_square_root u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #4 i_clk = ~i_clk;

    logic [31:0] pending_roots[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // Correctly rounded root of one single-precision pattern.
    function automatic logic [31:0] sqrt_rne(input logic [31:0] x);
        logic [7:0]  ex;
        logic [22:0] fr;
        logic [63:0] m;
        logic [63:0] rad;
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] q;
        int          e;
        int          rexp;
        ex = x[30:23];
        fr = x[22:0];
        if (ex == 8'hFF && fr != 0) return QUIET_NAN;
        if (x[30:0] == 0 || x[31]) return 32'h0;
        if (ex == 8'hFF) return EXP_MASK;
        if (ex == 0) begin
            m = {41'b0, fr};
            e = -149;
            while (!m[23]) begin
                m = m << 1;
                e = e - 1;
            end
        end else begin
            m = {40'b0, 1'b1, fr};
            e = int'(ex) - 150;
        end
        if (e % 2 != 0) begin
            m = m << 1;
            e = e - 1;
        end else begin
            m = m << 2;
            e = e - 2;
        end
        rad = m << 24;
        res = 0;
        bitv = 64'd1 << 48;
        while (bitv != 0) begin
            if (rad >= res + bitv) begin
                rad = rad - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        q = res >> 1;
        rexp = (e - 24) / 2 + 1 + 150;
        if (res[0] && (rad != 0 || q[0])) q = q + 1;
        if (q >= (64'd1 << 24)) begin
            q = q >> 1;
            rexp = rexp + 1;
        end
        return {rexp[8:0], q[22:0]};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Receiver: random stall, compare each taken root.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_roots.size() == 0) begin
                report_mismatch($sformatf("unexpected root %h", out_ch.data));
            end else begin
                logic [31:0] want;
                want = pending_roots.pop_front();
                if (out_ch.data !== want)
                    report_mismatch($sformatf("root_bits %h, expected %h", out_ch.data, want));
            end
        end
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no accepted request on either side.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // valid stays high after an accept until the next call drops or reuses it
    task automatic send_operand(input logic [31:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= x;
        pending_roots.push_back(sqrt_rne(x));
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic test_special_values();
        logic [31:0] vals[$] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
            32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF,
            32'h7FFF_FFFF, 32'h0000_0001, 32'h007F_FFFF, 32'h0040_0000,
            32'h0080_0000, 32'h7F7F_FFFF, 32'h3F80_0000, 32'h4080_0000,
            32'h4000_0000, 32'hBF80_0000, 32'h8000_0001, 32'h3F80_0001,
            32'h4040_0000, 32'h0000_0002};
        foreach (vals[i]) send_operand(vals[i]);
    endtask

    task automatic test_random_operands(input int count);
        logic [31:0] x;
        repeat (count) begin
            x = $urandom;
            case ($urandom_range(9))
                0: x[30:23] = 8'h00;
                1: x[30:23] = 8'hFF;
                2, 3, 4: x[31] = 1'b0;
                default: x[31] = 1'b0;
            endcase
            if ($urandom_range(9) == 0) x[31] = 1'b1;
            send_operand(x);
        end
    endtask

    task automatic test_idle_phase(input int s_pct, input int r_pct, input int count);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        test_random_operands(count);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_values();
        test_idle_phase(0, 0, 130);
        test_idle_phase(71, 0, 120);
        test_idle_phase(0, 71, 120);
        test_idle_phase(36, 36, 120);
        in_ch.valid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
